>>> hdl/im2col_ag_pkg.sv
// Shared types, register indexes and tap helpers for the im2col gather address generator.
package im2col_ag_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_IN_HEIGHT       = 3'd0;
    localparam logic [2:0] CFG_IN_WIDTH        = 3'd1;
    localparam logic [2:0] CFG_CHANNELS_PADDED = 3'd2;
    localparam logic [2:0] CFG_ROW_LENGTH      = 3'd3;
    localparam logic [2:0] CFG_STRIDE          = 3'd4;
    localparam logic [2:0] CFG_SRC_BASE        = 3'd5;
    localparam logic [2:0] CFG_DST_BASE        = 3'd6;

    // Special tap codes.
    localparam logic [3:0] TAP_FIRST       = 4'd0;
    localparam logic [3:0] TAP_LAST_KERNEL = 4'd8;
    localparam logic [3:0] TAP_TAIL        = 4'd9;

    // Stride code that selects a stride of two; every other code means one.
    localparam logic [1:0] STRIDE_TWO = 2'd2;

    // Configuration register file contents.
    typedef struct packed {
        logic [10:0] in_height;
        logic [10:0] in_width;
        logic [12:0] channels_padded;
        logic [15:0] row_length;
        logic [1:0]  stride;
        logic [31:0] src_base;
        logic [31:0] dst_base;
    } t_cfg;

    // One tap request handed from the sequencer to the address pipeline.
    typedef struct packed {
        logic [19:0] pix;
        logic [9:0]  orow;
        logic [9:0]  ocol;
        logic [3:0]  tap;
        logic        last;
    } t_tap_tok;

    // Kernel row of a tap (tap / 3).
    function automatic logic [1:0] tap_kh(input logic [3:0] tap);
        logic [1:0] kh;
        unique case (tap)
            4'd0, 4'd1, 4'd2: kh = 2'd0;
            4'd3, 4'd4, 4'd5: kh = 2'd1;
            4'd6, 4'd7, 4'd8: kh = 2'd2;
            default:          kh = 2'd0;
        endcase
        return kh;
    endfunction

    // Kernel column of a tap (tap % 3).
    function automatic logic [1:0] tap_kw(input logic [3:0] tap);
        logic [1:0] kw;
        unique case (tap)
            4'd0, 4'd3, 4'd6: kw = 2'd0;
            4'd1, 4'd4, 4'd7: kw = 2'd1;
            4'd2, 4'd5, 4'd8: kw = 2'd2;
            default:          kw = 2'd0;
        endcase
        return kw;
    endfunction

endpackage

>>> hdl/im2col_ag_seq.sv
// Tap sequencer: expands one pixel into nine or ten tap requests, one per cycle while the pipeline accepts them.
module im2col_ag_seq
    import im2col_ag_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  logic [19:0] i_pixel_index,
    input  logic [9:0]  i_out_row,
    input  logic [9:0]  i_out_col,
    output logic        o_stall,
    output logic        o_tok_valid,
    output t_tap_tok    o_tok,
    input  logic        i_tok_ready
);

    logic        r_valid;
    logic [19:0] r_pix;
    logic [9:0]  r_orow;
    logic [9:0]  r_ocol;
    logic [3:0]  r_tap;
    logic [3:0]  n_tap;
    logic [16:0] w_nine_c;
    logic        w_tail;
    logic        w_last;
    logic        w_adv;
    logic        w_load;

    // A tail descriptor exists when nine channel groups fall short of the row.
    assign w_nine_c = {1'b0, i_cfg.channels_padded, 3'b000} + 17'(i_cfg.channels_padded);
    assign w_tail   = w_nine_c < {1'b0, i_cfg.row_length};
    assign w_last   = w_tail ? (r_tap == TAP_TAIL) : (r_tap == TAP_LAST_KERNEL);

    // The held pixel frees up in the cycle its final tap moves on.
    assign w_adv   = r_valid && i_tok_ready;
    assign o_stall = r_valid && !(i_tok_ready && w_last);
    assign w_load  = i_valid && !o_stall;
    assign n_tap   = r_tap + 4'd1;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tap   <= TAP_FIRST;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_tap   <= TAP_FIRST;
        end else if (w_adv) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_tap <= n_tap;
            end
        end
    end

    // Pixel fields captured on each input transfer.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pix  <= i_pixel_index;
            r_orow <= i_out_row;
            r_ocol <= i_out_col;
        end
    end

    assign o_tok_valid = r_valid;
    assign o_tok.pix   = r_pix;
    assign o_tok.orow  = r_orow;
    assign o_tok.ocol  = r_ocol;
    assign o_tok.tap   = r_tap;
    assign o_tok.last  = w_last;

endmodule

>>> hdl/im2col_ag_pipe.sv
// Four-stage address pipeline: bounds check, products, sums and the output register.
module im2col_ag_pipe
    import im2col_ag_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_tok_valid,
    input  t_tap_tok    i_tok,
    output logic        o_tok_ready,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [3:0]  o_tap_index,
    output logic [32:0] o_src_addr,
    output logic [36:0] o_dst_addr,
    output logic [15:0] o_byte_count,
    output logic        o_zero_fill,
    output logic        o_last
);

    // Per-stage valid bits and ready chain.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4      = !r_v4 || !i_stall;
    assign w_rdy3      = !r_v3 || w_rdy4;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign o_tok_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_tok_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: neighbor position, bounds check, row product and tap offset.
    logic [10:0] w_orow_s;
    logic [10:0] w_ocol_s;
    logic [11:0] w_ihp;
    logic [11:0] w_iwp;
    logic        w_in_h;
    logic        w_in_w;
    logic        w_is_tail;

    assign w_is_tail = (i_tok.tap == TAP_TAIL);
    assign w_orow_s  = (i_cfg.stride == STRIDE_TWO) ? {i_tok.orow, 1'b0} : {1'b0, i_tok.orow};
    assign w_ocol_s  = (i_cfg.stride == STRIDE_TWO) ? {i_tok.ocol, 1'b0} : {1'b0, i_tok.ocol};
    // Positions are kept offset by one so that the padding row and column are zero.
    assign w_ihp  = {1'b0, w_orow_s} + {10'b0, tap_kh(i_tok.tap)};
    assign w_iwp  = {1'b0, w_ocol_s} + {10'b0, tap_kw(i_tok.tap)};
    assign w_in_h = (w_ihp != 12'd0) && (w_ihp <= {1'b0, i_cfg.in_height});
    assign w_in_w = (w_iwp != 12'd0) && (w_iwp <= {1'b0, i_cfg.in_width});

    logic [10:0] r_s1_ih;
    logic [10:0] r_s1_iw;
    logic        r_s1_inside;
    logic [35:0] r_s1_rowprod;
    logic [16:0] r_s1_off;
    logic [3:0]  r_s1_tap;
    logic        r_s1_last;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_tok_valid) begin
            r_s1_ih      <= 11'(w_ihp - 12'd1);
            r_s1_iw      <= 11'(w_iwp - 12'd1);
            r_s1_inside  <= w_in_h && w_in_w && !w_is_tail;
            r_s1_rowprod <= 36'(i_tok.pix) * 36'(i_cfg.row_length);
            r_s1_off     <= 17'(i_tok.tap) * 17'(i_cfg.channels_padded);
            r_s1_tap     <= i_tok.tap;
            r_s1_last    <= i_tok.last;
        end
    end

    // Stage 2: linear pixel index and the start of the destination row.
    logic [22:0] r_s2_lin;
    logic [36:0] r_s2_rowdst;
    logic [16:0] r_s2_off;
    logic        r_s2_inside;
    logic [3:0]  r_s2_tap;
    logic        r_s2_last;

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_s2_lin    <= 23'(r_s1_ih) * 23'(i_cfg.in_width) + 23'(r_s1_iw);
            r_s2_rowdst <= {5'b0, i_cfg.dst_base} + {1'b0, r_s1_rowprod};
            r_s2_off    <= r_s1_off;
            r_s2_inside <= r_s1_inside;
            r_s2_tap    <= r_s1_tap;
            r_s2_last   <= r_s1_last;
        end
    end

    // Stage 3: source byte offset and the destination address.
    logic [32:0] r_s3_srcprod;
    logic [36:0] r_s3_dst;
    logic [16:0] r_s3_off;
    logic        r_s3_inside;
    logic [3:0]  r_s3_tap;
    logic        r_s3_last;

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_s3_srcprod <= 33'(r_s2_lin) * 33'(i_cfg.channels_padded);
            r_s3_dst     <= r_s2_rowdst + 37'(r_s2_off);
            r_s3_off     <= r_s2_off;
            r_s3_inside  <= r_s2_inside;
            r_s3_tap     <= r_s2_tap;
            r_s3_last    <= r_s2_last;
        end
    end

    // Stage 4: output register with the source address and byte count.
    logic [3:0]  r_s4_tap;
    logic [32:0] r_s4_src;
    logic [36:0] r_s4_dst;
    logic [15:0] r_s4_count;
    logic        r_s4_zf;
    logic        r_s4_last;

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_s4_tap   <= r_s3_tap;
            r_s4_src   <= r_s3_inside ? ({1'b0, i_cfg.src_base} + r_s3_srcprod) : 33'd0;
            r_s4_dst   <= r_s3_dst;
            r_s4_count <= (r_s3_tap == TAP_TAIL) ? (i_cfg.row_length - r_s3_off[15:0])
                                                 : 16'(i_cfg.channels_padded);
            r_s4_zf    <= !r_s3_inside;
            r_s4_last  <= r_s3_last;
        end
    end

    assign o_valid      = r_v4;
    assign o_tap_index  = r_s4_tap;
    assign o_src_addr   = r_s4_src;
    assign o_dst_addr   = r_s4_dst;
    assign o_byte_count = r_s4_count;
    assign o_zero_fill  = r_s4_zf;
    assign o_last       = r_s4_last;

endmodule

>>> hdl/im2col_3x3_gather_address_gen_core.sv
// Top level of the 3x3 im2col gather address generator: registers, sequencer and pipeline.
// The first descriptor of a pixel passes the sequencer register and then every pipeline stage before it is valid.
// Throughput: one descriptor per cycle while the output is not stalled, nine per pixel or ten with a tail;
// the tap sequencer issues one tap per cycle and takes the next pixel as the last tap moves on.
// Stalls on the output freeze the pipeline without loss; bubbles close up.
// Reset is synchronous and active low: valid bits clear, registers take their defaults.
module im2col_3x3_gather_address_gen_core
    import im2col_ag_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_pixel_index,
    input  logic [9:0]  i_out_row,
    input  logic [9:0]  i_out_col,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_tap_index,
    output logic [32:0] o_src_addr,
    output logic [36:0] o_dst_addr,
    output logic [15:0] o_byte_count,
    output logic        o_zero_fill,
    output logic        o_last
);

    t_cfg     r_cfg;
    logic     w_tok_valid;
    logic     w_tok_ready;
    t_tap_tok w_tok;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_height       <= 11'd1;
            r_cfg.in_width        <= 11'd1;
            r_cfg.channels_padded <= 13'd16;
            r_cfg.row_length      <= 16'd144;
            r_cfg.stride          <= 2'd1;
            r_cfg.src_base        <= 32'd0;
            r_cfg.dst_base        <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IN_HEIGHT:       r_cfg.in_height       <= i_cfg_data[10:0];
                CFG_IN_WIDTH:        r_cfg.in_width        <= i_cfg_data[10:0];
                CFG_CHANNELS_PADDED: r_cfg.channels_padded <= i_cfg_data[12:0];
                CFG_ROW_LENGTH:      r_cfg.row_length      <= i_cfg_data[15:0];
                CFG_STRIDE:          r_cfg.stride          <= i_cfg_data[1:0];
                CFG_SRC_BASE:        r_cfg.src_base        <= i_cfg_data;
                CFG_DST_BASE:        r_cfg.dst_base        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Tap sequencer.
    im2col_ag_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .i_pixel_index (i_pixel_index),
        .i_out_row     (i_out_row),
        .i_out_col     (i_out_col),
        .o_stall       (o_stall),
        .o_tok_valid   (w_tok_valid),
        .o_tok         (w_tok),
        .i_tok_ready   (w_tok_ready)
    );

    // Address pipeline.
    im2col_ag_pipe u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_tok_valid  (w_tok_valid),
        .i_tok        (w_tok),
        .o_tok_ready  (w_tok_ready),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_tap_index  (o_tap_index),
        .o_src_addr   (o_src_addr),
        .o_dst_addr   (o_dst_addr),
        .o_byte_count (o_byte_count),
        .o_zero_fill  (o_zero_fill),
        .o_last       (o_last)
    );

    // An input transfer always starts the sequencer at the first tap.
    a_load_first_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (w_tok_valid && w_tok.tap == TAP_FIRST))
        else $error("sequencer did not restart at the first tap");

    // A zero-fill descriptor never carries a source address.
    a_zero_fill_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_fill) |-> (o_src_addr == 33'd0))
        else $error("zero-fill descriptor with a nonzero source address");

    // The tail descriptor is always the last one and always a zero fill.
    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tap_index == TAP_TAIL) |-> (o_last && o_zero_fill))
        else $error("tail descriptor not marked last and zero fill");

    // Only kernel taps and the tail code leave the block.
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tap_index <= TAP_TAIL))
        else $error("tap index out of range");

endmodule
